>>> rtl/buddy_free_map_coalescer_macros.svh
`ifndef BUDDY_FREE_MAP_COALESCER_MACROS_SVH
`define BUDDY_FREE_MAP_COALESCER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define BFM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define BFM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bfm_pkg.sv
package bfm_pkg;

    localparam int ADDR_BITS_DEF = 10;
    localparam int MAX_ROW_BITS  = 32;
    localparam int OP_W          = 2;
    localparam int ORDER_W       = 4;
    localparam int STATUS_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_COALESCE = 2'd1,
        OP_PROBE    = 2'd2,
        OP_FIND     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_DUP = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_CO_RD_CHILD,
        S_CO_RD_PARENT,
        S_CO_WR_PARENT,
        S_FI_INIT,
        S_FI_RD,
        S_FI_EVAL,
        S_DONE
    } state_t;

endpackage

>>> rtl/bfm_if.sv
interface bfm_cmd_if import bfm_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [ORDER_W-1:0]   order;
    logic [ADDR_BITS-1:0] addr;

    modport source (output valid, operation, order, addr, input ready);
    modport sink   (input valid, operation, order, addr, output ready);
endinterface

interface bfm_rsp_if import bfm_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [ADDR_BITS-1:0] result_addr;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, found, result_addr, status, input ready);
    modport sink   (input valid, found, result_addr, status, output ready);
endinterface

>>> rtl/bfm_first_set.sv
module bfm_first_set import bfm_pkg::*; #(
    parameter int W = MAX_ROW_BITS
) (
    input  logic [W-1:0]         vec,
    output logic                 hit,
    output logic [$clog2(W)-1:0] pos
);
    localparam int PW = $clog2(W);

    // Lowest set bit wins: scan from the top down.
    always_comb
    begin
        hit = |vec;
        pos = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                pos = PW'(i);
            end
        end
    end
endmodule

>>> rtl/buddy_free_map_coalescer.sv
// Channel | Dir | Payload                          | Handshake
// cmd     | in  | operation, order, addr           | valid/ready
// rsp     | out | found, result_addr, status       | valid/ready
//
// Insert and probe read one map row, then check it; insert writes the row back.
// Coalesce walks each child row of orders 0..ADDR_BITS-1 (read child, read parent
// while clearing child, write parent) on separate read and write ports.
// Find scans the orders lowest first: per order an init step, then a read and an
// evaluate step per scanned row.
// After reset the map memory is cleared one row a cycle, all MEM_DEPTH rows (352 at
// ADDR_BITS=10); cmd is not ready meanwhile.
// A result waiting in the rsp register does not block the next command; a finished
// command holds in its done state only while that register is still full.
`include "buddy_free_map_coalescer_macros.svh"

module buddy_free_map_coalescer import bfm_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bfm_cmd_if.sink   cmd,
    bfm_rsp_if.source rsp
);
    localparam int MAX_LOG_W = $clog2(MAX_ROW_BITS);
    localparam int LOG_W     = (ADDR_BITS - 1 < MAX_LOG_W) ? ADDR_BITS - 1 : MAX_LOG_W;
    localparam int W         = 1 << LOG_W;
    localparam int HALF_W    = W / 2;
    localparam int WORD_BITS = ADDR_BITS - LOG_W;
    localparam int ORD_W     = $clog2(ADDR_BITS + 1);
    localparam int ROW_W     = ORD_W + WORD_BITS;
    localparam int MEM_DEPTH = (ADDR_BITS + 1) << WORD_BITS;

    localparam logic [ORD_W-1:0]     TOP_ORD     = ORD_W'(ADDR_BITS);
    localparam logic [ORD_W-1:0]     LAST_CO_ORD = ORD_W'(ADDR_BITS - 1);
    localparam logic [ORD_W-1:0]     ORD_ONE     = ORD_W'(1);
    localparam logic [ROW_W-1:0]     CLR_LAST    = ROW_W'(MEM_DEPTH - 1);
    localparam logic [ADDR_BITS:0]   SI_ONE      = (ADDR_BITS + 1)'(1);
    localparam logic [WORD_BITS-1:0] WORD_ONE    = WORD_BITS'(1);

    // Map memory: row {order, word}, bit = (base >> order) mod W
    logic [W-1:0]     mem [MEM_DEPTH];
    logic [W-1:0]     rd_data_reg;
    logic             mem_we;
    logic [ROW_W-1:0] mem_wa;
    logic [W-1:0]     mem_wd;
    logic             mem_re;
    logic [ROW_W-1:0] mem_ra;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic [ROW_W-1:0] clr_reg;

    op_t                  op_reg;
    logic                 ok_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [LOG_W-1:0]     bit_reg;
    logic [ORD_W-1:0]     ord_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic                 first_reg;
    logic [LOG_W-1:0]     pos_reg;
    logic [HALF_W-1:0]    merge_reg;
    logic                 best_valid_reg;
    logic [ADDR_BITS-1:0] best_reg;

    logic                 res_found_reg;
    logic [ADDR_BITS-1:0] res_addr_reg;
    status_t              res_status_reg;
    logic                 out_found_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;
    status_t              out_status_reg;

    logic                 cmd_accept;
    logic                 misalign;
    logic                 cmd_ok;
    logic [ADDR_BITS-1:0] cmd_idx;
    logic [ROW_W-1:0]     cmd_row;
    logic [LOG_W-1:0]     cmd_bit;

    logic [ROW_W-1:0]     child_row;
    logic [ROW_W-1:0]     parent_row;
    logic [WORD_BITS-1:0] last_word;
    logic [HALF_W-1:0]    pair_m;
    logic [W-1:0]         pair_mask;
    logic [W-1:0]         child_clear;
    logic [W-1:0]         parent_new;

    logic [ADDR_BITS:0]   si_round;
    logic [ADDR_BITS:0]   si;
    logic [ADDR_BITS:0]   si_limit;
    logic                 si_skip;
    logic [W-1:0]         ge_mask;
    logic [W-1:0]         scan_row;
    logic                 fs_hit;
    logic [LOG_W-1:0]     fs_pos;
    logic [ADDR_BITS-1:0] cand;
    logic                 best_upd;
    logic                 new_valid;
    logic [ADDR_BITS-1:0] new_best;

    logic                 slot_free;
    logic                 out_load;
    logic                 fin;
    logic                 fin_found;
    logic [ADDR_BITS-1:0] fin_addr;
    status_t              fin_status;

    assign cmd_accept = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE);
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign out_load   = fin && slot_free;

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.result_addr = out_addr_reg;
    assign rsp.status      = out_status_reg;

    // Range and alignment check of the incoming block
    always_comb
    begin
        misalign = 1'b0;
        for (int i = 0; i < ADDR_BITS; i++)
        begin
            if (cmd.addr[i] && (i < int'(cmd.order)))
            begin
                misalign = 1'b1;
            end
        end
        cmd_ok  = (int'(cmd.order) <= ADDR_BITS) && !misalign;
        cmd_idx = cmd.addr >> cmd.order;
        cmd_row = {ORD_W'(cmd.order), cmd_idx[ADDR_BITS-1:LOG_W]};
        cmd_bit = cmd_idx[LOG_W-1:0];
    end

    // Coalesce row datapath
    always_comb
    begin
        for (int i = 0; i < HALF_W; i++)
        begin
            pair_m[i]          = rd_data_reg[2*i] & rd_data_reg[2*i+1];
            pair_mask[2*i]     = pair_m[i];
            pair_mask[2*i+1]   = pair_m[i];
        end
        child_row   = {ord_reg, word_reg};
        parent_row  = {ord_reg + ORD_ONE, word_reg >> 1};
        last_word   = {WORD_BITS{1'b1}} >> ord_reg;
        child_clear = rd_data_reg & ~pair_mask;
        parent_new  = rd_data_reg | (word_reg[0] ? {merge_reg, {HALF_W{1'b0}}}
                                                 : {{HALF_W{1'b0}}, merge_reg});
    end

    // Find datapath: first index at or above the start, per order
    always_comb
    begin
        si_round = (SI_ONE << ord_reg) - SI_ONE;
        si       = ({1'b0, addr_reg} + si_round) >> ord_reg;
        si_limit = SI_ONE << (TOP_ORD - ord_reg);
        si_skip  = (si >= si_limit);
        for (int i = 0; i < W; i++)
        begin
            ge_mask[i] = (i >= int'(pos_reg));
        end
        scan_row = rd_data_reg & (first_reg ? ge_mask : {W{1'b1}});
    end

    bfm_first_set #(
        .W (W)
    ) u_first_set (
        .vec (scan_row),
        .hit (fs_hit),
        .pos (fs_pos)
    );

    always_comb
    begin
        cand      = {word_reg, fs_pos} << ord_reg;
        best_upd  = (state_reg == S_FI_EVAL) && fs_hit && (!best_valid_reg || cand < best_reg);
        new_valid = best_valid_reg || best_upd;
        new_best  = best_upd ? cand : best_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_wa     = child_row;
        mem_wd     = '0;
        mem_re     = 1'b0;
        mem_ra     = child_row;
        fin        = 1'b0;
        fin_found  = 1'b0;
        fin_addr   = '0;
        fin_status = ST_OK;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    case (cmd.operation)
                        OP_INSERT, OP_PROBE:
                        begin
                            mem_re     = cmd_ok;
                            mem_ra     = cmd_row;
                            state_next = S_CHECK;
                        end
                        OP_COALESCE: state_next = S_CO_RD_CHILD;
                        default:     state_next = S_FI_INIT;
                    endcase
                end
            end
            S_CHECK:
            begin
                fin = 1'b1;
                if (!ok_reg)
                begin
                    fin_status = ST_BAD;
                end
                else if (op_reg == OP_INSERT)
                begin
                    if (rd_data_reg[bit_reg])
                    begin
                        fin_status = ST_DUP;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wa = row_reg;
                        mem_wd = rd_data_reg | ({{(W-1){1'b0}}, 1'b1} << bit_reg);
                    end
                end
                else
                begin
                    fin_found = rd_data_reg[bit_reg];
                    fin_addr  = rd_data_reg[bit_reg] ? addr_reg : '0;
                end
            end
            S_CO_RD_CHILD:
            begin
                mem_re     = 1'b1;
                state_next = S_CO_RD_PARENT;
            end
            S_CO_RD_PARENT:
            begin
                // drop merged pairs from the child row, fetch the parent row
                mem_we     = 1'b1;
                mem_wd     = child_clear;
                mem_re     = 1'b1;
                mem_ra     = parent_row;
                state_next = S_CO_WR_PARENT;
            end
            S_CO_WR_PARENT:
            begin
                mem_we     = 1'b1;
                mem_wa     = parent_row;
                mem_wd     = parent_new;
                state_next = S_CO_RD_CHILD;
                if (word_reg == last_word && ord_reg == LAST_CO_ORD)
                begin
                    fin = 1'b1;
                end
            end
            S_FI_INIT:
            begin
                if (!si_skip)
                begin
                    state_next = S_FI_RD;
                end
                else if (ord_reg == TOP_ORD)
                begin
                    fin       = 1'b1;
                    fin_found = new_valid;
                    fin_addr  = new_valid ? new_best : '0;
                end
            end
            S_FI_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_FI_EVAL;
            end
            S_FI_EVAL:
            begin
                if (fs_hit || word_reg == last_word)
                begin
                    state_next = S_FI_INIT;
                    if (ord_reg == TOP_ORD)
                    begin
                        fin       = 1'b1;
                        fin_found = new_valid;
                        fin_addr  = new_valid ? new_best : '0;
                    end
                end
                else
                begin
                    state_next = S_FI_RD;
                end
            end
            S_DONE:
            begin
                fin        = 1'b1;
                fin_found  = res_found_reg;
                fin_addr   = res_addr_reg;
                fin_status = res_status_reg;
            end
            default: state_next = S_IDLE;
        endcase

        if (fin)
        begin
            state_next = slot_free ? S_IDLE : S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg  <= fin_found;
            out_addr_reg   <= fin_addr;
            out_status_reg <= fin_status;
        end
        // hold the result until the output register frees up
        if (fin && !slot_free)
        begin
            res_found_reg  <= fin_found;
            res_addr_reg   <= fin_addr;
            res_status_reg <= fin_status;
        end
        if (cmd_accept)
        begin
            op_reg         <= op_t'(cmd.operation);
            ok_reg         <= cmd_ok;
            addr_reg       <= cmd.addr;
            row_reg        <= cmd_row;
            bit_reg        <= cmd_bit;
            ord_reg        <= '0;
            word_reg       <= '0;
            best_valid_reg <= 1'b0;
        end
        case (state_reg)
            S_CO_RD_PARENT:
            begin
                merge_reg <= pair_m;
            end
            S_CO_WR_PARENT:
            begin
                if (word_reg == last_word)
                begin
                    ord_reg  <= ord_reg + ORD_ONE;
                    word_reg <= '0;
                end
                else
                begin
                    word_reg <= word_reg + WORD_ONE;
                end
            end
            S_FI_INIT:
            begin
                if (si_skip)
                begin
                    ord_reg <= ord_reg + ORD_ONE;
                end
                else
                begin
                    word_reg  <= si[ADDR_BITS-1:LOG_W];
                    pos_reg   <= si[LOG_W-1:0];
                    first_reg <= 1'b1;
                end
            end
            S_FI_EVAL:
            begin
                best_valid_reg <= new_valid;
                best_reg       <= new_best;
                // first hit in an order is its lowest base: on a hit or after the last word, advance to the next order
                if (fs_hit || word_reg == last_word)
                begin
                    ord_reg <= ord_reg + ORD_ONE;
                end
                else
                begin
                    word_reg  <= word_reg + WORD_ONE;
                    first_reg <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    `BFM_ASSERT_NXT(a_one_item_at_a_time, clk, rst_n, cmd.valid && cmd.ready, !cmd.ready, "item accepted while a command is in flight")
    `BFM_ASSERT_IMP(a_no_write_when_idle, clk, rst_n, state_reg == S_IDLE, !mem_we, "map written while idle")
    `BFM_ASSERT_IMP(a_insert_only_clear_bit, clk, rst_n, mem_we && state_reg == S_CHECK, op_reg == OP_INSERT && ok_reg && !rd_data_reg[bit_reg], "insert wrote a bad or duplicate block")
    `BFM_ASSERT_IMP(a_addr_zero_if_missing, clk, rst_n, rsp.valid && !rsp.found, rsp.result_addr == '0, "result address set without a found block")

endmodule
